@@ rtl/core/rms_pkg.sv @@
package rms_pkg;

	// Width of the configuration register index
	localparam int CFG_IDX_W = 3;

	// Configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_PHASE_INC = 3'd1,
		REG_AMPLITUDE = 3'd2,
		REG_OFFS_PROB = 3'd3,
		REG_GATE_LEN  = 3'd4,
		REG_SYNC_EN   = 3'd5,
		REG_SYNC_LVL  = 3'd6,
		REG_SEQ_LEN   = 3'd7
	} reg_idx_t;

	// Trigger actions; codes 5 to 7 do nothing
	localparam int MODE_W = 3;
	typedef enum logic [MODE_W-1:0] {
		MODE_NOISE    = 3'd0,
		MODE_CRAWL    = 3'd1,
		MODE_INTERVAL = 3'd2,
		MODE_CHAOS    = 3'd3,
		MODE_SEQUENCE = 3'd4
	} mode_t;

	// Input beat kinds
	typedef enum logic {
		KIND_TICK  = 1'b0,
		KIND_TABLE = 1'b1
	} kind_t;

endpackage

@@ rtl/core/rms_if.sv @@
// Sample / table-write input channel
interface rms_in_if #(
	parameter int VALUE_BITS = 16,
	parameter int SLOT_BITS  = 4
);
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [VALUE_BITS-1:0] mod_level;
	logic [VALUE_BITS-1:0] random_first;
	logic [VALUE_BITS-1:0] random_second;
	logic [SLOT_BITS-1:0]  table_slot;
	logic [VALUE_BITS-1:0] table_word;

	modport source (
		output valid, kind, mod_level, random_first, random_second, table_slot, table_word,
		input  ready
	);
	modport sink (
		input  valid, kind, mod_level, random_first, random_second, table_slot, table_word,
		output ready
	);
endinterface

// Result channel
interface rms_out_if #(
	parameter int VALUE_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] level;
	logic                  gate_out;

	modport source (output valid, level, gate_out, input ready);
	modport sink (input valid, level, gate_out, output ready);
endinterface

// Configuration write channel
interface rms_cfg_if #(
	parameter int IDX_W  = 3,
	parameter int DATA_W = 24
);
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/rms_cfg_regs.sv @@
module rms_cfg_regs #(
	parameter int SEQ_DEPTH  = 16,
	parameter int PHASE_BITS = 24,
	parameter int VALUE_BITS = 16,
	parameter int LEN_W      = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rms_cfg_if.sink                     cfg,
	output logic [rms_pkg::MODE_W-1:0]  mode,
	output logic                        mode_wr,
	output logic [PHASE_BITS-1:0]       phase_inc,
	output logic [VALUE_BITS-1:0]       amplitude,
	output logic [VALUE_BITS-1:0]       amp_tenth,
	output logic [VALUE_BITS-1:0]       offs_prob,
	output logic [PHASE_BITS-1:0]       gate_len,
	output logic                        sync_en,
	output logic [VALUE_BITS-1:0]       sync_lvl,
	output logic [LEN_W-1:0]            seq_len
);
	import rms_pkg::*;

	// floor(x/10) as x * ceil-ish reciprocal >> (VALUE_BITS+4); exact for x < 2**VALUE_BITS
	localparam int RECIP_SHIFT = VALUE_BITS + 4;
	localparam logic [VALUE_BITS:0] RECIP = (VALUE_BITS+1)'((1 << RECIP_SHIFT) / 10 + 1);

	logic [VALUE_BITS-1:0] wr_value;
	logic [2*VALUE_BITS:0] tenth_prod;
	logic [VALUE_BITS-1:0] tenth_nxt;

	assign cfg.ready  = 1'b1;
	assign wr_value   = cfg.data[VALUE_BITS-1:0];
	assign tenth_prod = {{VALUE_BITS{1'b0}}, RECIP} * {{(VALUE_BITS+1){1'b0}}, wr_value};
	assign tenth_nxt  = VALUE_BITS'(tenth_prod >> RECIP_SHIFT);
	assign mode_wr    = cfg.valid && (reg_idx_t'(cfg.index) == REG_MODE);

	// Register file; amplitude/10 is taken along with the amplitude write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode      <= MODE_W'(MODE_NOISE);
			phase_inc <= '0;
			amplitude <= '0;
			amp_tenth <= '0;
			offs_prob <= '0;
			gate_len  <= PHASE_BITS'(1) << (PHASE_BITS - 1);
			sync_en   <= 1'b0;
			sync_lvl  <= VALUE_BITS'(1) << (VALUE_BITS - 1);
			seq_len   <= LEN_W'(SEQ_DEPTH);
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_MODE:      mode      <= cfg.data[MODE_W-1:0];
				REG_PHASE_INC: phase_inc <= cfg.data[PHASE_BITS-1:0];
				REG_AMPLITUDE: begin
					amplitude <= wr_value;
					amp_tenth <= tenth_nxt;
				end
				REG_OFFS_PROB: offs_prob <= wr_value;
				REG_GATE_LEN:  gate_len  <= cfg.data[PHASE_BITS-1:0];
				REG_SYNC_EN:   sync_en   <= cfg.data[0];
				REG_SYNC_LVL:  sync_lvl  <= wr_value;
				REG_SEQ_LEN:   seq_len   <= cfg.data[LEN_W-1:0];
				default:       ;
			endcase
		end
	end

endmodule

@@ rtl/core/rms_seq_mem.sv @@
module rms_seq_mem #(
	parameter int SEQ_DEPTH  = 16,
	parameter int VALUE_BITS = 16,
	parameter int ADDR_W     = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [ADDR_W-1:0]     waddr,
	input  logic [VALUE_BITS-1:0] wdata,
	input  logic                  re,
	input  logic [ADDR_W-1:0]     raddr,
	output logic [VALUE_BITS-1:0] rdata
);
	logic [VALUE_BITS-1:0] mem [SEQ_DEPTH];
	logic [SEQ_DEPTH-1:0]  vld_q;
	logic [VALUE_BITS-1:0] rd_q;
	logic                  rd_vld_q;

	// Storage array, no reset
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// Per-entry written flags; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

@@ rtl/core/rms_core.sv @@
module rms_core #(
	parameter int SEQ_DEPTH  = 16,
	parameter int PHASE_BITS = 24,
	parameter int VALUE_BITS = 16,
	parameter int STEP_W     = 4,
	parameter int LEN_W      = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rms_in_if.sink                      din,
	rms_out_if.source                   dout,
	input  logic [rms_pkg::MODE_W-1:0]  mode,
	input  logic                        mode_wr,
	input  logic [PHASE_BITS-1:0]       phase_inc,
	input  logic [VALUE_BITS-1:0]       amplitude,
	input  logic [VALUE_BITS-1:0]       amp_tenth,
	input  logic [VALUE_BITS-1:0]       offs_prob,
	input  logic [PHASE_BITS-1:0]       gate_len,
	input  logic                        sync_en,
	input  logic [VALUE_BITS-1:0]       sync_lvl,
	input  logic [LEN_W-1:0]            seq_len,
	output logic                        mem_we,
	output logic [STEP_W-1:0]           mem_waddr,
	output logic [VALUE_BITS-1:0]       mem_wdata,
	output logic                        mem_re,
	output logic [STEP_W-1:0]           mem_raddr,
	input  logic [VALUE_BITS-1:0]       mem_rdata
);
	import rms_pkg::*;

	localparam logic [VALUE_BITS-1:0] FULL = '1;

	// State
	logic [VALUE_BITS-1:0] held_q;
	logic                  held_in_mem_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic                  gate_q;
	logic                  latch_q;
	logic [STEP_W-1:0]     step_q;

	// Output stage
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_level_q;
	logic                  out_gate_q;
	logic                  out_from_mem_q;

	logic                    accept;
	logic                    tick;
	logic [VALUE_BITS-1:0]   held_cur;
	logic                    trig;
	logic                    latch_nxt;
	logic [VALUE_BITS-1:0]   mul_a;
	logic [2*VALUE_BITS-1:0] prod;
	logic [VALUE_BITS-1:0]   scaled;
	logic [VALUE_BITS:0]     noise_sum;
	logic [VALUE_BITS:0]     up_sum;
	logic [VALUE_BITS-1:0]   crawl_up;
	logic [VALUE_BITS-1:0]   crawl_dn;
	logic                    change;
	logic [LEN_W-1:0]        len_eff;
	logic [LEN_W-1:0]        step_inc;
	logic [VALUE_BITS-1:0]   held_nxt;
	logic                    gate_trig;
	logic [STEP_W-1:0]       step_nxt;
	logic                    seq_rd;
	logic [PHASE_BITS:0]     phase_sum;
	logic [PHASE_BITS-1:0]   phase_nxt;
	logic                    gate_nxt;

	// Handshake: output register frees as it drains
	assign din.ready = !out_valid_q || dout.ready;
	assign accept    = din.valid && din.ready;
	assign tick      = accept && (kind_t'(din.kind) == KIND_TICK);

	// Held value may still sit in the memory read register after a sequence step
	assign held_cur = held_in_mem_q ? mem_rdata : held_q;

	// Trigger decision
	always_comb begin
		trig      = 1'b0;
		latch_nxt = latch_q;
		if (!sync_en) begin
			trig = (phase_q == '0);
		end else if (latch_q) begin
			latch_nxt = (din.mod_level >= sync_lvl);
		end else if (din.mod_level >= sync_lvl) begin
			latch_nxt = 1'b1;
			trig      = 1'b1;
		end
	end

	// Shared scaler: random draw times amplitude
	assign mul_a  = (mode_t'(mode) == MODE_CHAOS) ? din.random_second : din.random_first;
	assign prod   = {{VALUE_BITS{1'b0}}, mul_a} * {{VALUE_BITS{1'b0}}, amplitude};
	assign scaled = prod[2*VALUE_BITS-1:VALUE_BITS];

	assign noise_sum = {1'b0, scaled} + {1'b0, offs_prob};
	assign up_sum    = {1'b0, held_cur} + {1'b0, amp_tenth};
	assign crawl_up  = up_sum[VALUE_BITS] ? FULL : up_sum[VALUE_BITS-1:0];
	assign crawl_dn  = (held_cur > amp_tenth) ? (held_cur - amp_tenth) : '0;
	assign change    = din.random_first > offs_prob;

	// Sequence step wraps at the effective length
	assign len_eff  = (seq_len == '0) ? LEN_W'(1) :
		(seq_len > LEN_W'(SEQ_DEPTH)) ? LEN_W'(SEQ_DEPTH) : seq_len;
	assign step_inc = LEN_W'(step_q) + LEN_W'(1);

	// Mode action on a trigger
	always_comb begin
		held_nxt  = held_cur;
		gate_trig = gate_q;
		step_nxt  = step_q;
		seq_rd    = 1'b0;
		if (trig) begin
			case (mode_t'(mode))
				MODE_NOISE: begin
					held_nxt  = noise_sum[VALUE_BITS] ? FULL : noise_sum[VALUE_BITS-1:0];
					gate_trig = 1'b1;
				end
				MODE_CRAWL: begin
					held_nxt  = (step_q == '0) ? crawl_up : crawl_dn;
					gate_trig = 1'b1;
					if (change) begin
						step_nxt = (step_q == '0) ? STEP_W'(1) : '0;
					end
				end
				MODE_INTERVAL: begin
					if (change) begin
						if (held_cur == amplitude) begin
							held_nxt = '0;
						end else begin
							held_nxt  = amplitude;
							gate_trig = 1'b1;
						end
					end
				end
				MODE_CHAOS: begin
					if (change) begin
						held_nxt  = scaled;
						gate_trig = 1'b1;
					end
				end
				MODE_SEQUENCE: begin
					step_nxt  = (step_inc >= len_eff) ? '0 : step_inc[STEP_W-1:0];
					seq_rd    = 1'b1;
					gate_trig = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Phase advance, wrap to zero on carry, then gate
	assign phase_sum = {1'b0, phase_q} + {1'b0, phase_inc};
	assign phase_nxt = phase_sum[PHASE_BITS] ? '0 : phase_sum[PHASE_BITS-1:0];
	assign gate_nxt  = sync_en ? latch_nxt : ((phase_nxt > gate_len) ? 1'b0 : gate_trig);

	// Table access
	assign mem_we    = accept && (kind_t'(din.kind) == KIND_TABLE) &&
		({1'b0, din.table_slot} < (STEP_W+1)'(SEQ_DEPTH));
	assign mem_waddr = din.table_slot;
	assign mem_wdata = din.table_word;
	assign mem_re    = tick && seq_rd;
	assign mem_raddr = step_nxt;

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q        <= '0;
			held_in_mem_q <= 1'b0;
			phase_q       <= '0;
			gate_q        <= 1'b0;
			latch_q       <= 1'b0;
			step_q        <= '0;
		end else if (mode_wr) begin
			step_q <= '0;
		end else if (tick) begin
			if (seq_rd) begin
				held_in_mem_q <= 1'b1;
			end else begin
				held_q        <= held_nxt;
				held_in_mem_q <= 1'b0;
			end
			phase_q <= phase_nxt;
			gate_q  <= gate_nxt;
			latch_q <= latch_nxt;
			step_q  <= step_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			out_level_q    <= held_nxt;
			out_gate_q     <= gate_nxt;
			out_from_mem_q <= seq_rd;
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.level    = out_from_mem_q ? mem_rdata : out_level_q;
	assign dout.gate_out = out_gate_q;

endmodule

@@ rtl/core/random_modulation_source.sv @@
// Random modulation source.
// Channels: din carries one beat per sample tick (kind = tick) with the external
// modulation level and two uniform random draws, or a sequence table write
// (kind = table) of table_word into table_slot. dout returns one beat per tick:
// the held level and the gate. Table writes return nothing. cfg writes one
// register per beat and is always ready; write it only while the block is idle.
// Throughput: one din beat per cycle while dout.ready holds. Latency: a tick's
// result is on dout the cycle after its din beat. The update is a combinational
// read of the state registers plus one multiplier; the sequence table is a synchronous
// memory whose read lands in the cycle after the tick, feeding dout directly.
// Stall: dout is a one-entry output register; din.ready stays high while that
// register is empty or draining, and drops while a result waits unread.
// Reset: all state clears, the table reads as zero until written, registers
// take their defaults (gate length and sync level at half scale, sequence
// length at full depth). No clearing pass is needed.
module random_modulation_source #(
	parameter int SEQ_DEPTH  = 16,
	parameter int PHASE_BITS = 24,
	parameter int VALUE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rms_cfg_if.sink   cfg,
	rms_in_if.sink    din,
	rms_out_if.source dout
);
	import rms_pkg::*;

	localparam int STEP_W = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
	localparam int LEN_W  = $clog2(SEQ_DEPTH + 1);

	logic [MODE_W-1:0]     mode;
	logic                  mode_wr;
	logic [PHASE_BITS-1:0] phase_inc;
	logic [VALUE_BITS-1:0] amplitude;
	logic [VALUE_BITS-1:0] amp_tenth;
	logic [VALUE_BITS-1:0] offs_prob;
	logic [PHASE_BITS-1:0] gate_len;
	logic                  sync_en;
	logic [VALUE_BITS-1:0] sync_lvl;
	logic [LEN_W-1:0]      seq_len;

	logic                  mem_we;
	logic [STEP_W-1:0]     mem_waddr;
	logic [VALUE_BITS-1:0] mem_wdata;
	logic                  mem_re;
	logic [STEP_W-1:0]     mem_raddr;
	logic [VALUE_BITS-1:0] mem_rdata;

	rms_cfg_regs #(
		.SEQ_DEPTH  (SEQ_DEPTH),
		.PHASE_BITS (PHASE_BITS),
		.VALUE_BITS (VALUE_BITS),
		.LEN_W      (LEN_W)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mode      (mode),
		.mode_wr   (mode_wr),
		.phase_inc (phase_inc),
		.amplitude (amplitude),
		.amp_tenth (amp_tenth),
		.offs_prob (offs_prob),
		.gate_len  (gate_len),
		.sync_en   (sync_en),
		.sync_lvl  (sync_lvl),
		.seq_len   (seq_len)
	);

	rms_seq_mem #(
		.SEQ_DEPTH  (SEQ_DEPTH),
		.VALUE_BITS (VALUE_BITS),
		.ADDR_W     (STEP_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	rms_core #(
		.SEQ_DEPTH  (SEQ_DEPTH),
		.PHASE_BITS (PHASE_BITS),
		.VALUE_BITS (VALUE_BITS),
		.STEP_W     (STEP_W),
		.LEN_W      (LEN_W)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.dout      (dout),
		.mode      (mode),
		.mode_wr   (mode_wr),
		.phase_inc (phase_inc),
		.amplitude (amplitude),
		.amp_tenth (amp_tenth),
		.offs_prob (offs_prob),
		.gate_len  (gate_len),
		.sync_en   (sync_en),
		.sync_lvl  (sync_lvl),
		.seq_len   (seq_len),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

@@ rtl/core/rms_chk.sv @@
module rms_chk #(
	parameter int VALUE_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  in_kind,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [VALUE_BITS-1:0] out_level,
	input logic                  out_gate
);
	import rms_pkg::*;

	// An empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	// Every accepted tick shows a result on the next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind_t'(in_kind) == KIND_TICK) |=> out_valid)
		else $error("tick produced no result");

	// A table write creates no result
	a_table_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind_t'(in_kind) == KIND_TABLE) |=> !out_valid)
		else $error("table write produced a result");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_gate))
		else $error("stalled result changed");

endmodule

bind random_modulation_source rms_chk #(
	.VALUE_BITS (VALUE_BITS)
) u_rms_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.in_kind   (din.kind),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_level (dout.level),
	.out_gate  (dout.gate_out)
);
